// File: rtl/core/rdlp_pkg.sv
`timescale 1ns / 1ps
// rdlp_pkg: shared types, constants and lookup tables of the rotating dot pattern
// no dependencies

package rdlp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_LEDS = 64;
  localparam int MAX_DOTS = 16;
  localparam int DIV_STEPS = 48;
  localparam logic [16:0] ONE = 17'h10000;
  localparam logic [15:0] DEFAULT_PERIOD = 16'd1000;
  localparam logic [15:0] DEFAULT_WIDTH = 16'd655;
  localparam logic [11:0] MIN_EXPONENT = 12'd256;

  typedef enum logic [2:0] {
    REG_LED_COUNT = 3'd0,
    REG_DOT_COUNT = 3'd1,
    REG_PERIOD    = 3'd2,
    REG_DOT_WIDTH = 3'd3,
    REG_EXPONENT  = 3'd4,
    REG_MIN_BRIGHT = 3'd5,
    REG_BASE_COLOR = 3'd6
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_WAIT,
    ST_POS_START,
    ST_POS_WAIT,
    ST_DOT_START,
    ST_DOT_WAIT,
    ST_DIST,
    ST_X_WAIT,
    ST_LOG,
    ST_MUL1,
    ST_EXP,
    ST_MUL2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef logic [255:0][16:0] tab_t;

  function automatic tab_t build_log_tab();
    tab_t t;
    logic [63:0] v;
    logic [17:0] r;
    for (int m = 0; m < 256; m++) begin
      v = 64'(256 + m) << 22;
      r = '0;
      for (int b = 0; b <= FRAC_BITS; b++) begin
        v = (v * v) >> 30;
        r = r << 1;
        if (v >= (64'd1 << 31)) begin
          v = v >> 1;
          r = r | 18'd1;
        end
      end
      t[m] = 17'((r + 18'd1) >> 1);
    end
    return t;
  endfunction

  function automatic tab_t build_exp_tab();
    tab_t t;
    logic [63:0] v;
    logic [63:0] roots [8];
    roots[0] = 64'd3037000500; roots[1] = 64'd3611622603;
    roots[2] = 64'd3938502376; roots[3] = 64'd4112874773;
    roots[4] = 64'd4202935003; roots[5] = 64'd4248701965;
    roots[6] = 64'd4271771996; roots[7] = 64'd4283353945;
    for (int j = 0; j < 256; j++) begin
      v = 64'd1 << 32;
      for (int b = 0; b < 8; b++) begin
        if (((j >> (7 - b)) & 1) == 1) begin
          v = (v * roots[b] + (64'd1 << 31)) >> 32;
        end
      end
      t[j] = 17'((v + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    end
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_log_tab();
  localparam tab_t EXP_TAB = build_exp_tab();

endpackage

// File: rtl/core/rdlp_div.sv
`timescale 1ns / 1ps
// rdlp_div: shared restoring divider, one quotient bit per cycle
// depends on rdlp_pkg

module rdlp_div (
  input  logic               clk,
  input  logic               rst,
  input  rdlp_pkg::div_req_t req,
  output logic [47:0]        quotient,
  output logic               done,
  output logic               busy
);

  logic [15:0] rem;
  logic [15:0] dv;
  logic [5:0]  cnt;
  logic [16:0] shifted;
  logic        ge;
  logic [15:0] rem_next;
  logic [47:0] quo_next;

  always_comb begin
    shifted = {rem, quotient[47]};
    ge = shifted >= {1'b0, dv};
    rem_next = ge ? 16'(shifted - {1'b0, dv}) : shifted[15:0];
    quo_next = {quotient[46:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(rdlp_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quotient <= req.dividend;
      dv <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quotient <= quo_next;
    end
  end

endmodule

// File: rtl/core/rotating_dot_led_pattern_top.sv
`timescale 1ns / 1ps
// rotating_dot_led_pattern_top: rotating dot ring pattern, one rgb transaction per led
// depends on rdlp_pkg and rdlp_div

// One timestamp transaction yields one color transaction per LED, in LED order. All
// divisions share one restoring divider, and each division holds the sequencer until
// the divider is done; the falloff division runs only for the LED and dot pairs that lie
// within the dot width, and a finished color waits on m_tready; input is not ready
// until the frame is done.

module rotating_dot_led_pattern_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // time_ms
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // led_index[5:0], red, green, blue, zero pad
  output logic        m_tlast,   // last_led
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [6:0]  led_count;
  logic [4:0]  dot_num;
  logic [15:0] period_ms;
  logic [15:0] dot_span;
  logic [11:0] falloff_exp;
  logic [7:0]  min_brightness;
  logic [23:0] base_color;

  rdlp_pkg::state_t state, state_next;
  logic [31:0] prev_time;
  logic [15:0] phase;
  logic [6:0]  led_i;
  logic [4:0]  dot_k;
  logic [15:0] pos;
  logic [15:0] dp;
  logic [20:0] nlog;
  logic [24:0] y;
  logic [16:0] ival;
  logic [16:0] bright;

  logic [6:0]  n_eff;
  logic [4:0]  dots_eff;
  logic [15:0] per_eff;
  logic [15:0] w_eff;
  logic [11:0] e_eff;
  logic [16:0] minf;
  logic [31:0] delta;
  logic        in_acc;
  logic        out_free;

  rdlp_pkg::div_req_t div_req;
  logic [47:0] quo;
  logic        div_done;
  logic        div_busy;

  logic [16:0] dist_raw;
  logic [15:0] ring_dist;
  logic [16:0] x;
  logic [4:0]  p;
  logic [16:0] norm;
  logic [20:0] nlog_c;
  logic [32:0] prod1;
  logic [8:0]  kshift;
  logic [16:0] ival_c;
  logic [33:0] prod2;
  logic [16:0] val;
  logic [16:0] bright_c;
  logic [24:0] pr, pg, pb;

  rdlp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .quotient (quo),
    .done     (div_done),
    .busy     (div_busy)
  );

  always_comb begin
    n_eff = (led_count > 7'(rdlp_pkg::MAX_LEDS)) ? 7'(rdlp_pkg::MAX_LEDS) : led_count;
    if (dot_num == 5'd0) dots_eff = 5'd1;
    else if (dot_num > 5'(rdlp_pkg::MAX_DOTS)) dots_eff = 5'(rdlp_pkg::MAX_DOTS);
    else dots_eff = dot_num;
    per_eff = (period_ms == 16'd0) ? rdlp_pkg::DEFAULT_PERIOD : period_ms;
    w_eff = (dot_span == 16'd0) ? rdlp_pkg::DEFAULT_WIDTH : dot_span;
    e_eff = (falloff_exp < rdlp_pkg::MIN_EXPONENT) ? rdlp_pkg::MIN_EXPONENT
                                                   : falloff_exp;
    minf = {1'b0, min_brightness, 8'h00};
    delta = (prev_time == 32'd0) ? 32'd0 : s_tdata - prev_time;
    s_tready = (state == rdlp_pkg::ST_IDLE);
    in_acc = s_tvalid && s_tready;
    out_free = !m_tvalid || m_tready;
  end

  // distance and falloff datapath
  always_comb begin
    dist_raw = (pos > dp) ? {1'b0, pos - dp} : {1'b0, dp - pos};
    ring_dist = (dist_raw > 17'd32768) ? 16'(17'h10000 - dist_raw) : dist_raw[15:0];
    x = 17'h10000 - quo[16:0];
    p = '0;
    for (int b = 0; b < 17; b++) begin
      if (x[b]) p = 5'(b);
    end
    norm = x << (5'd16 - p);
    nlog_c = (21'(5'd16 - p) << 16) - 21'(rdlp_pkg::LOG_TAB[norm[15:8]]);
    prod1 = 33'(nlog) * 33'(e_eff);
    kshift = y[24:16];
    ival_c = (kshift > 9'd16) ? 17'd0 : (rdlp_pkg::EXP_TAB[y[15:8]] >> kshift[4:0]);
    prod2 = 34'(rdlp_pkg::ONE - minf) * 34'(ival);
    val = minf + prod2[32:16];
    bright_c = (bright > rdlp_pkg::ONE) ? rdlp_pkg::ONE : bright;
    pr = 25'(base_color[23:16]) * 25'(bright_c);
    pg = 25'(base_color[15:8]) * 25'(bright_c);
    pb = 25'(base_color[7:0]) * 25'(bright_c);
  end

  always_comb begin
    state_next = state;
    div_req = '0;
    case (state)
      rdlp_pkg::ST_IDLE: begin
        if (in_acc && led_count != 7'd0) begin
          div_req.start = 1'b1;
          div_req.dividend = {delta, 16'h0000};
          div_req.divisor = per_eff;
          state_next = rdlp_pkg::ST_PH_WAIT;
        end
      end
      rdlp_pkg::ST_PH_WAIT: if (div_done) state_next = rdlp_pkg::ST_POS_START;
      rdlp_pkg::ST_POS_START: begin
        div_req.start = 1'b1;
        div_req.dividend = 48'(led_i) << 16;
        div_req.divisor = 16'(n_eff);
        state_next = rdlp_pkg::ST_POS_WAIT;
      end
      rdlp_pkg::ST_POS_WAIT: if (div_done) state_next = rdlp_pkg::ST_DOT_START;
      rdlp_pkg::ST_DOT_START: begin
        div_req.start = 1'b1;
        div_req.dividend = 48'(dot_k) << 16;
        div_req.divisor = 16'(dots_eff);
        state_next = rdlp_pkg::ST_DOT_WAIT;
      end
      rdlp_pkg::ST_DOT_WAIT: if (div_done) state_next = rdlp_pkg::ST_DIST;
      rdlp_pkg::ST_DIST: begin
        if (ring_dist < w_eff) begin
          div_req.start = 1'b1;
          div_req.dividend = 48'(ring_dist) << 16;
          div_req.divisor = w_eff;
          state_next = rdlp_pkg::ST_X_WAIT;
        end else if (dot_k + 5'd1 == dots_eff) begin
          state_next = rdlp_pkg::ST_OUT;
        end else begin
          state_next = rdlp_pkg::ST_DOT_START;
        end
      end
      rdlp_pkg::ST_X_WAIT: if (div_done) state_next = rdlp_pkg::ST_LOG;
      rdlp_pkg::ST_LOG: state_next = rdlp_pkg::ST_MUL1;
      rdlp_pkg::ST_MUL1: state_next = rdlp_pkg::ST_EXP;
      rdlp_pkg::ST_EXP: state_next = rdlp_pkg::ST_MUL2;
      rdlp_pkg::ST_MUL2: begin
        state_next = (dot_k + 5'd1 == dots_eff) ? rdlp_pkg::ST_OUT : rdlp_pkg::ST_DOT_START;
      end
      rdlp_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = (led_i + 7'd1 == n_eff) ? rdlp_pkg::ST_IDLE : rdlp_pkg::ST_POS_START;
        end
      end
      default: state_next = rdlp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdlp_pkg::ST_IDLE;
      prev_time <= '0;
      phase <= '0;
      m_tvalid <= 1'b0;
      led_count <= 7'd64;
      dot_num <= 5'd5;
      period_ms <= 16'd1200;
      dot_span <= 16'd7864;
      falloff_exp <= 12'd640;
      min_brightness <= 8'd13;
      base_color <= 24'hFFFFFF;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          rdlp_pkg::REG_LED_COUNT:  led_count <= cfg_data[6:0];
          rdlp_pkg::REG_DOT_COUNT:  dot_num <= cfg_data[4:0];
          rdlp_pkg::REG_PERIOD:     period_ms <= cfg_data[15:0];
          rdlp_pkg::REG_DOT_WIDTH:  dot_span <= cfg_data[15:0];
          rdlp_pkg::REG_EXPONENT:   falloff_exp <= cfg_data[11:0];
          rdlp_pkg::REG_MIN_BRIGHT: min_brightness <= cfg_data[7:0];
          rdlp_pkg::REG_BASE_COLOR: base_color <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && led_count != 7'd0) prev_time <= s_tdata;
      if (state == rdlp_pkg::ST_PH_WAIT && div_done) phase <= phase + quo[15:0];
      if (state == rdlp_pkg::ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rdlp_pkg::ST_IDLE: led_i <= '0;
      rdlp_pkg::ST_POS_WAIT: begin
        pos <= quo[15:0];
        dot_k <= '0;
        bright <= minf;
      end
      rdlp_pkg::ST_DOT_WAIT: dp <= phase + quo[15:0];
      rdlp_pkg::ST_DIST: if (ring_dist >= w_eff) dot_k <= dot_k + 5'd1;
      rdlp_pkg::ST_LOG: nlog <= nlog_c;
      rdlp_pkg::ST_MUL1: y <= prod1[32:8];
      rdlp_pkg::ST_EXP: ival <= ival_c;
      rdlp_pkg::ST_MUL2: begin
        if (val > bright) bright <= val;
        dot_k <= dot_k + 5'd1;
      end
      rdlp_pkg::ST_OUT: begin
        if (out_free) begin
          m_tdata <= {2'b00, pb[23:16], pg[23:16], pr[23:16], led_i[5:0]};
          m_tlast <= (led_i + 7'd1 == n_eff);
          led_i <= led_i + 7'd1;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy) else $error("divider started while busy");
  a_frame_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && led_count != 7'd0) |=> (state == rdlp_pkg::ST_PH_WAIT))
    else $error("frame did not start");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (7'(m_tdata[5:0]) + 7'd1 == n_eff))
    else $error("last flag on wrong led");
`endif

endmodule
